// ===== src/tgle_pkg.sv =====
// Shared types, constants and the microcode program of the thermal gain/loss estimator.
package tgle_pkg;

  localparam int DT_WIDTH = 24;
  localparam int DEN_W    = (DT_WIDTH > 17) ? DT_WIDTH : 17;
  localparam int NUM_W    = 48;
  localparam int PROD_W   = 63;
  localparam int SUM_W    = 50;
  localparam int PC_W     = 4;

  localparam logic [16:0]        ALPHA_ONE   = 17'd65536;
  localparam logic [16:0]        ALPHA_RESET = 17'd6554;
  localparam logic signed [30:0] MS_HOUR_Q8  = 31'sd921600000;
  localparam logic signed [16:0] MIN_DIFF    = 17'sd25;

  localparam logic signed [62:0] SAT_HI = 63'sd2147483647;
  localparam logic signed [62:0] SAT_LO = -63'sd2147483648;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh80000000;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_GAIN = 2'd1;
  localparam logic [1:0] KIND_LOSS = 2'd2;

  typedef struct packed {
    logic signed [15:0]    prev_temp;
    logic                  prev_valid;
    logic signed [15:0]    now_temp;
    logic                  now_valid;
    logic signed [15:0]    outdoor_temp;
    logic                  outdoor_valid;
    logic [DT_WIDTH-1:0]   elapsed_ms;
    logic                  heater_on;
    logic                  away;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         update_kind;
    logic signed [31:0] gain_rate;
    logic               gain_known;
    logic signed [31:0] loss_coeff;
    logic               loss_known;
  } out_word_t;

  // Sequencer conditions
  localparam logic [2:0] C_NEXT  = 3'd0;
  localparam logic [2:0] C_IN    = 3'd1;
  localparam logic [2:0] C_SKIP  = 3'd2;
  localparam logic [2:0] C_NHEAT = 3'd3;
  localparam logic [2:0] C_DIV   = 3'd4;
  localparam logic [2:0] C_JUMP  = 3'd5;
  localparam logic [2:0] C_OUT   = 3'd6;

  // Multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_RATE = 3'd1;
  localparam logic [2:0] MUL_EST  = 3'd2;
  localparam logic [2:0] MUL_NEW  = 3'd3;
  localparam logic [2:0] MUL_OLD  = 3'd4;

  // Divider launches
  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_RATE = 2'd1;
  localparam logic [1:0] DIV_LOSS = 2'd2;

  // Register write selects
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_RATE  = 3'd1;
  localparam logic [2:0] WR_GROSS = 3'd2;
  localparam logic [2:0] WR_COEFF = 3'd3;
  localparam logic [2:0] WR_SUM   = 3'd4;
  localparam logic [2:0] WR_ACC   = 3'd5;
  localparam logic [2:0] WR_OUT   = 3'd6;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
  localparam logic [PC_W-1:0] PC_MRATE = 4'd2;
  localparam logic [PC_W-1:0] PC_DRATE = 4'd3;
  localparam logic [PC_W-1:0] PC_WRATE = 4'd4;
  localparam logic [PC_W-1:0] PC_FORK  = 4'd5;
  localparam logic [PC_W-1:0] PC_MEST  = 4'd6;
  localparam logic [PC_W-1:0] PC_GROSS = 4'd7;
  localparam logic [PC_W-1:0] PC_DLOSS = 4'd8;
  localparam logic [PC_W-1:0] PC_WLOSS = 4'd9;
  localparam logic [PC_W-1:0] PC_MNEW  = 4'd10;
  localparam logic [PC_W-1:0] PC_MOLD  = 4'd11;
  localparam logic [PC_W-1:0] PC_EMA   = 4'd12;
  localparam logic [PC_W-1:0] PC_PUT   = 4'd13;

  typedef struct packed {
    logic [2:0]      cond;
    logic [2:0]      mul;
    logic [1:0]      div;
    logic [2:0]      wr;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{cond: C_NEXT, mul: MUL_NONE, div: DIV_NONE, wr: WR_NONE, target: PC_IDLE};
    case (pc)
      PC_IDLE:  w.cond = C_IN;
      PC_CHECK: begin
        w.cond   = C_SKIP;
        w.target = PC_PUT;
      end
      PC_MRATE: w.mul = MUL_RATE;
      PC_DRATE: w.div = DIV_RATE;
      PC_WRATE: begin
        w.cond = C_DIV;
        w.wr   = WR_RATE;
      end
      PC_FORK:  begin
        w.cond   = C_NHEAT;
        w.target = PC_DLOSS;
      end
      PC_MEST:  w.mul = MUL_EST;
      PC_GROSS: begin
        w.wr     = WR_GROSS;
        w.cond   = C_JUMP;
        w.target = PC_MNEW;
      end
      PC_DLOSS: w.div = DIV_LOSS;
      PC_WLOSS: begin
        w.cond = C_DIV;
        w.wr   = WR_COEFF;
      end
      PC_MNEW:  w.mul = MUL_NEW;
      PC_MOLD:  begin
        w.mul = MUL_OLD;
        w.wr  = WR_SUM;
      end
      PC_EMA:   w.wr = WR_ACC;
      PC_PUT:   begin
        w.cond   = C_OUT;
        w.wr     = WR_OUT;
        w.target = PC_IDLE;
      end
      default:  begin
        w.cond   = C_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    if (v > SAT_HI) return INT_MAX;
    else if (v < SAT_LO) return INT_MIN;
    else return $signed(v[31:0]);
  endfunction

  // Apply a sign to an unsigned quotient and saturate.
  function automatic logic signed [31:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
    if (neg) begin
      if (q > NUM_W'(64'd2147483648)) return INT_MIN;
      else return $signed(32'd0 - q[31:0]);
    end else begin
      if (q > NUM_W'(64'd2147483647)) return INT_MAX;
      else return $signed(q[31:0]);
    end
  endfunction

endpackage

// ===== src/tgle_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
module tgle_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tgle_pkg::NUM_W-1:0]  num,
  input  logic [tgle_pkg::DEN_W-1:0]  den,
  output logic                        busy,
  output logic [tgle_pkg::NUM_W-1:0]  quo
);

  localparam int STEPS = tgle_pkg::NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tgle_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [tgle_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [tgle_pkg::DEN_W-1:0]  den_r;

  // Two dependent shift-compare-subtract steps; quotient bits fill num from the bottom.
  always_comb begin
    logic [tgle_pkg::DEN_W:0]    t;
    logic [tgle_pkg::NUM_W-1:0]  n;
    logic [tgle_pkg::DEN_W-1:0]  r;
    n = num_r;
    r = rem_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, n[tgle_pkg::NUM_W-1]};
      n = {n[tgle_pkg::NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t    = t - {1'b0, den_r};
        n[0] = 1'b1;
      end
      r = t[tgle_pkg::DEN_W-1:0];
    end
    num_nxt  = n;
    rem_nxt  = r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider launched while busy");

  a_rose_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start)) else $error("divider busy without a launch");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !start) |=> !busy_r) else $error("divider overran its count");

endmodule

// ===== src/thermal_gain_loss_estimator_unit.sv =====
// Top level of the thermal gain/loss estimator: microcoded sequencer and datapath.
// A word is accepted, then checked: a skipped word goes straight to the result register,
// a gain update passes one divide and a loss update two. One word is in work at a time;
// the next can be taken the cycle after the result is registered. Each divide holds the
// sequencer while the shared radix-4 divider runs (48 quotient bits, 2 per cycle).
// Reset (synchronous, rst_n low) clears both estimates and seeds, sets alpha_r to 6554.
module thermal_gain_loss_estimator_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tgle_pkg::in_word_t     in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tgle_pkg::out_word_t    out_word,
  input  logic                   cfg_wr_en,
  input  logic [16:0]            cfg_wr_data
);

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  logic [tgle_pkg::PC_W-1:0]           pc_r, pc_nxt;
  logic [16:0]                         alpha_r;
  tgle_pkg::in_word_t                  item_r;
  logic signed [31:0]                  gain_acc_r, loss_acc_r;
  logic                                gain_seed_r, loss_seed_r;
  logic signed [31:0]                  rate_r;   // degrees per hour, Q24.8
  logic signed [31:0]                  x_r;      // new EMA sample
  logic signed [tgle_pkg::PROD_W-1:0]  prod_r;
  logic signed [tgle_pkg::SUM_W-1:0]   sum_r;    // alpha * new sample
  logic [1:0]                          kind_r;
  logic                                out_valid_r;
  tgle_pkg::out_word_t                 out_word_r;

  tgle_pkg::uword_t                    cw;
  logic                                in_acc, out_free, stall, no_learn;

  // ---------------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------------
  logic signed [16:0] dtemp, diff;
  logic [15:0]        dtemp_mag;
  logic [31:0]        rate_mag;
  logic               heat_case, cool_case, est_on;
  logic [16:0]        alpha_eff;

  assign dtemp     = 17'(item_r.now_temp) - 17'(item_r.prev_temp);
  assign diff      = 17'(item_r.now_temp) - 17'(item_r.outdoor_temp);
  assign dtemp_mag = dtemp[16] ? 16'(-dtemp) : dtemp[15:0];
  assign rate_mag  = rate_r[31] ? (32'd0 - rate_r) : rate_r;
  assign heat_case = item_r.heater_on && (dtemp > 17'sd0);
  assign cool_case = !item_r.heater_on && (dtemp < 17'sd0) && (diff > tgle_pkg::MIN_DIFF);
  assign est_on    = loss_seed_r && (diff > 17'sd0);
  assign alpha_eff = (alpha_r > tgle_pkg::ALPHA_ONE) ? tgle_pkg::ALPHA_ONE : alpha_r;

  // Skip on any invalid reading, zero elapsed time, away mode, or no matching regime.
  assign no_learn = !(item_r.prev_valid && item_r.now_valid && item_r.outdoor_valid)
                    || (item_r.elapsed_ms == '0) || item_r.away
                    || !(heat_case || cool_case);

  // ---------------------------------------------------------------------------
  // Control word fetch and step counter
  // ---------------------------------------------------------------------------
  logic div_busy;

  assign cw       = tgle_pkg::ucode(pc_r);
  assign in_ready = (cw.cond == tgle_pkg::C_IN);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign stall    = ((cw.cond == tgle_pkg::C_IN)  && !in_valid)
                 || ((cw.cond == tgle_pkg::C_DIV) && div_busy)
                 || ((cw.cond == tgle_pkg::C_OUT) && !out_free);

  always_comb begin
    pc_nxt = pc_r + 1'b1;
    case (cw.cond)
      tgle_pkg::C_NEXT:  pc_nxt = pc_r + 1'b1;
      tgle_pkg::C_IN:    pc_nxt = in_valid ? pc_r + 1'b1 : pc_r;
      tgle_pkg::C_SKIP:  pc_nxt = no_learn ? cw.target : pc_r + 1'b1;
      tgle_pkg::C_NHEAT: pc_nxt = !item_r.heater_on ? cw.target : pc_r + 1'b1;
      tgle_pkg::C_DIV:   pc_nxt = div_busy ? pc_r : pc_r + 1'b1;
      tgle_pkg::C_JUMP:  pc_nxt = cw.target;
      tgle_pkg::C_OUT:   pc_nxt = out_free ? cw.target : pc_r;
      default:           pc_nxt = tgle_pkg::PC_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: 32 x 31 signed, product registered
  // ---------------------------------------------------------------------------
  logic signed [31:0]                  mul_a;
  logic signed [30:0]                  mul_b;
  logic signed [tgle_pkg::PROD_W-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      tgle_pkg::MUL_RATE: begin
        mul_a = $signed({16'b0, dtemp_mag});
        mul_b = tgle_pkg::MS_HOUR_Q8;
      end
      tgle_pkg::MUL_EST: begin
        // Zero operand when the loss estimate does not apply.
        mul_a = est_on ? loss_acc_r : 32'sd0;
        mul_b = 31'(diff);
      end
      tgle_pkg::MUL_NEW: begin
        mul_a = x_r;
        mul_b = $signed({14'b0, alpha_eff});
      end
      tgle_pkg::MUL_OLD: begin
        mul_a = item_r.heater_on ? gain_acc_r : loss_acc_r;
        mul_b = $signed({14'b0, tgle_pkg::ALPHA_ONE - alpha_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Shared divider: magnitudes in, sign applied on write-back
  // ---------------------------------------------------------------------------
  logic                         div_start;
  logic [tgle_pkg::NUM_W-1:0]   div_num, div_quo;
  logic [tgle_pkg::DEN_W-1:0]   div_den;

  assign div_start = !stall && (cw.div != tgle_pkg::DIV_NONE);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cw.div)
      tgle_pkg::DIV_RATE: begin
        div_num = prod_r[tgle_pkg::NUM_W-1:0];
        div_den = tgle_pkg::DEN_W'(item_r.elapsed_ms);
      end
      tgle_pkg::DIV_LOSS: begin
        div_num = tgle_pkg::NUM_W'({rate_mag, 8'b0});
        div_den = tgle_pkg::DEN_W'(diff[15:0]);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tgle_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Write-back values
  // ---------------------------------------------------------------------------
  logic signed [tgle_pkg::PROD_W-1:0]  est_adj, est_sh, gross_sum;
  logic signed [31:0]                  est_val, gross;
  logic signed [tgle_pkg::SUM_W-1:0]   ema_tot, ema_adj;
  logic signed [31:0]                  ema_val, acc_new;

  // Loss estimate: loss_acc * diff / 256, truncated toward zero.
  assign est_adj   = prod_r + (prod_r[tgle_pkg::PROD_W-1] ? 63'sd255 : 63'sd0);
  assign est_sh    = est_adj >>> 8;
  assign est_val   = tgle_pkg::sat32(est_sh);
  assign gross_sum = tgle_pkg::PROD_W'(rate_r) + tgle_pkg::PROD_W'(est_val);
  assign gross     = tgle_pkg::sat32(gross_sum);

  // EMA: (a*new + (1-a)*old) / 65536 toward zero; lies between old and new.
  assign ema_tot = sum_r + $signed(prod_r[tgle_pkg::SUM_W-1:0]);
  assign ema_adj = ema_tot
                 + $signed({{(tgle_pkg::SUM_W-16){1'b0}}, {16{ema_tot[tgle_pkg::SUM_W-1]}}});
  assign ema_val = $signed(ema_adj[47:16]);

  always_comb begin
    if (item_r.heater_on) acc_new = gain_seed_r ? ema_val : x_r;
    else acc_new = loss_seed_r ? ema_val : x_r;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tgle_pkg::PC_IDLE;
      alpha_r     <= tgle_pkg::ALPHA_RESET;
      gain_acc_r  <= '0;
      gain_seed_r <= 1'b0;
      loss_acc_r  <= '0;
      loss_seed_r <= 1'b0;
      kind_r      <= tgle_pkg::KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) alpha_r <= cfg_wr_data;
      if (in_acc) kind_r <= tgle_pkg::KIND_NONE;
      // Commit the EMA into the selected estimate.
      if (!stall && cw.wr == tgle_pkg::WR_ACC) begin
        if (item_r.heater_on) begin
          gain_acc_r  <= acc_new;
          gain_seed_r <= 1'b1;
          kind_r      <= tgle_pkg::KIND_GAIN;
        end else begin
          loss_acc_r  <= acc_new;
          loss_seed_r <= 1'b1;
          kind_r      <= tgle_pkg::KIND_LOSS;
        end
      end
      // Hold the result until taken; free the slot on a take.
      if (!stall && cw.wr == tgle_pkg::WR_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_word;
    if (!stall && cw.mul != tgle_pkg::MUL_NONE) prod_r <= prod;
    if (!stall) begin
      case (cw.wr)
        tgle_pkg::WR_RATE:  rate_r <= tgle_pkg::sat_quo(div_quo, dtemp[16]);
        tgle_pkg::WR_GROSS: x_r <= gross;
        tgle_pkg::WR_COEFF: x_r <= tgle_pkg::sat_quo(div_quo, rate_r > 32'sd0);
        tgle_pkg::WR_SUM:   sum_r <= prod_r[tgle_pkg::SUM_W-1:0];
        tgle_pkg::WR_OUT: begin
          out_word_r.update_kind <= kind_r;
          out_word_r.gain_rate   <= gain_acc_r;
          out_word_r.gain_known  <= gain_seed_r;
          out_word_r.loss_coeff  <= loss_acc_r;
          out_word_r.loss_known  <= loss_seed_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_seed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(gain_seed_r) && !$fell(loss_seed_r))
    else $error("seed flag dropped outside reset");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy) else $error("taking a word while the divider runs");

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.update_kind != tgle_pkg::KIND_GAIN || out_word_r.gain_known)
                 && (out_word_r.update_kind != tgle_pkg::KIND_LOSS || out_word_r.loss_known))
    else $error("update reported for an unseeded estimate");

  a_put_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == tgle_pkg::PC_PUT)
    else $error("result raised outside the output step");

endmodule
